// ===== rtl/core/asdc_pkg.sv =====
package asdc_pkg;

  localparam int REQ_W      = 3;
  localparam int ENC_W      = 12;
  localparam int POS_W      = 12;
  localparam int MAN_W      = 9;
  localparam int LVL_W      = 8;
  localparam int FSD_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int ENC_MAX    = 4095;
  localparam int STEP_SIZE  = 25;
  localparam int STEP_COUNT = 10;
  localparam int STEP_CNT_W = 4;

  localparam logic [REQ_W-1:0] REQ_SET_TARGET = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SYNC       = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ABORT      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MANUAL     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_DRIVE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CREEP_DRIVE     = 2'd2;

  localparam logic [FSD_W-1:0] FSD_RST   = 12'd64;
  localparam logic [LVL_W-1:0] FULL_RST  = 8'd255;
  localparam logic [LVL_W-1:0] CREEP_RST = 8'd22;
  localparam logic [LVL_W-1:0] LVL_MAX   = 8'd255;

  typedef struct packed {
    logic [FSD_W-1:0] full_speed_distance;
    logic [LVL_W-1:0] full_drive;
    logic [LVL_W-1:0] creep_drive;
  } cfg_t;

  typedef struct packed {
    logic             slewing;
    logic             clockwise;
    logic [LVL_W-1:0] drive_level;
  } res_t;

  function automatic logic [LVL_W-1:0] step_drive(input logic [STEP_CNT_W-1:0] steps);
    logic [LVL_W-1:0] lvl;
    case (steps)
      4'd0:    lvl = 8'd0;
      4'd1:    lvl = 8'd25;
      4'd2:    lvl = 8'd50;
      4'd3:    lvl = 8'd75;
      4'd4:    lvl = 8'd100;
      4'd5:    lvl = 8'd125;
      4'd6:    lvl = 8'd150;
      4'd7:    lvl = 8'd175;
      4'd8:    lvl = 8'd200;
      4'd9:    lvl = 8'd225;
      default: lvl = 8'd250;
    endcase
    return lvl;
  endfunction

endpackage

// ===== rtl/core/axis_slew_drive_controller_top.sv =====
// Slew drive controller for one rotary axis. Each request (set target, sync,
// control tick, abort, manual drive, reverse) enters an input register and its
// result, the drive level, direction and slewing flag after the request, is
// loaded into the result register on the next advance: one request per clock
// sustained while the output is not stalled. The result register is the
// controller state itself, so every request sees the state left by the one
// before. The tick path, encoder modulo reduction by compare-subtract steps,
// modular offset and distance, then the drive select, sits between those two
// registers. Configuration writes take effect at once and are meant for idle
// periods; nothing needs to be cleared after reset.
module axis_slew_drive_controller_top
  import asdc_pkg::*;
#(
  parameter int COUNTS_PER_TURN = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] encoder_count, [23:12] position, [32:24] manual_drive, [39:33] zero
  input  logic [39:0]           in_tdata,
  // [2:0] req_type
  input  logic [REQ_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] drive_level, [8] clockwise, [9] slewing, [15:10] zero
  output logic [15:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PW = $clog2(COUNTS_PER_TURN);

  cfg_t                    cfg_r;
  logic                    s1_valid_r;
  logic [REQ_W-1:0]        s1_req_r;
  logic [ENC_W-1:0]        s1_enc_r;
  logic [POS_W-1:0]        s1_pos_r;
  logic signed [MAN_W-1:0] s1_man_r;
  logic                    out_valid_r;
  logic [PW-1:0]           target_r;
  logic [PW-1:0]           sync_r;
  res_t                    cur_r;
  logic [PW-1:0]           target_nxt;
  logic [PW-1:0]           sync_nxt;
  res_t                    res_nxt;
  logic                    adv;
  logic                    in_acc;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_speed_distance <= FSD_RST;
      cfg_r.full_drive          <= FULL_RST;
      cfg_r.creep_drive         <= CREEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FULL_SPEED_DIST: cfg_r.full_speed_distance <= cfg_wdata;
        CFG_FULL_DRIVE:      cfg_r.full_drive          <= cfg_wdata[LVL_W-1:0];
        CFG_CREEP_DRIVE:     cfg_r.creep_drive         <= cfg_wdata[LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_tuser;
      s1_enc_r <= in_tdata[11:0];
      s1_pos_r <= in_tdata[23:12];
      s1_man_r <= $signed(in_tdata[32:24]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  asdc_step #(
    .COUNTS_PER_TURN(COUNTS_PER_TURN),
    .PW             (PW)
  ) u_step (
    .cfg       (cfg_r),
    .req       (s1_req_r),
    .enc       (s1_enc_r),
    .pos       (s1_pos_r),
    .man       (s1_man_r),
    .target    (target_r),
    .sync      (sync_r),
    .cur       (cur_r),
    .target_nxt(target_nxt),
    .sync_nxt  (sync_nxt),
    .res_nxt   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r          <= '0;
      sync_r            <= '0;
      cur_r.drive_level <= '0;
      cur_r.clockwise   <= 1'b1;
      cur_r.slewing     <= 1'b0;
    end else if (adv) begin
      target_r <= target_nxt;
      sync_r   <= sync_nxt;
      cur_r    <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, cur_r.slewing, cur_r.clockwise, cur_r.drive_level};

`ifndef NO_ASSERTIONS
  a_target_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(target_r) < 32'(COUNTS_PER_TURN))
    else $error("target count outside one turn");

  a_sync_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sync_r) < 32'(COUNTS_PER_TURN))
    else $error("sync offset outside one turn");

  a_abort_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_req_r == REQ_ABORT) |=>
      (out_tvalid && cur_r.drive_level == '0 && !cur_r.slewing))
    else $error("abort did not stop the axis");

  a_target_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_req_r == REQ_SET_TARGET && 32'(s1_pos_r) < 32'(COUNTS_PER_TURN)) |=>
      (cur_r.slewing && 32'(target_r) == 32'($past(s1_pos_r))))
    else $error("set target did not start slewing");
`endif

endmodule

// ===== rtl/core/asdc_mod_reduce.sv =====
module asdc_mod_reduce
  import asdc_pkg::*;
#(
  parameter int COUNTS_PER_TURN = 4096,
  parameter int PW              = $clog2(COUNTS_PER_TURN)
) (
  input  logic [ENC_W-1:0] enc,
  output logic [PW-1:0]    enc_mod
);

  logic [ENC_W-1:0] rem;

  always_comb begin
    rem = enc;
    for (int k = ENC_W - 1; k >= 0; k--) begin
      if ((COUNTS_PER_TURN << k) <= ENC_MAX) begin
        if (rem >= ENC_W'(COUNTS_PER_TURN << k)) begin
          rem = rem - ENC_W'(COUNTS_PER_TURN << k);
        end
      end
    end
  end

  assign enc_mod = PW'(rem);

endmodule

// ===== rtl/core/asdc_step.sv =====
module asdc_step
  import asdc_pkg::*;
#(
  parameter int COUNTS_PER_TURN = 4096,
  parameter int PW              = $clog2(COUNTS_PER_TURN)
) (
  input  cfg_t              cfg,
  input  logic [REQ_W-1:0]  req,
  input  logic [ENC_W-1:0]  enc,
  input  logic [POS_W-1:0]  pos,
  input  logic signed [MAN_W-1:0] man,
  input  logic [PW-1:0]     target,
  input  logic [PW-1:0]     sync,
  input  res_t              cur,
  output logic [PW-1:0]     target_nxt,
  output logic [PW-1:0]     sync_nxt,
  output res_t              res_nxt
);

  localparam logic [PW:0]   N_C    = (PW+1)'(COUNTS_PER_TURN);
  localparam logic [PW-1:0] HALF_C = PW'(COUNTS_PER_TURN / 2);

  logic [PW-1:0]         enc_mod;
  logic                  pos_ok;
  logic [PW-1:0]         pos_w;
  logic [PW:0]           sync_sum;
  logic [PW:0]           user_sum;
  logic [PW-1:0]         user;
  logic [PW:0]           cw_sum;
  logic [PW-1:0]         cw_dist;
  logic [PW-1:0]         near_dist;
  logic                  tick_cw;
  logic [STEP_CNT_W-1:0] steps;
  logic [LVL_W-1:0]      tick_lvl;
  logic                  tick_stop;
  logic [MAN_W-1:0]      man_u;
  logic [MAN_W-1:0]      man_mag;

  asdc_mod_reduce #(
    .COUNTS_PER_TURN(COUNTS_PER_TURN),
    .PW             (PW)
  ) u_reduce (
    .enc    (enc),
    .enc_mod(enc_mod)
  );

  assign pos_ok = (32'(pos) < 32'(COUNTS_PER_TURN));
  assign pos_w  = PW'(pos);

  always_comb begin
    sync_sum = {1'b0, pos_w} - {1'b0, enc_mod};
    if (pos_w < enc_mod) begin
      sync_sum = sync_sum + N_C;
    end
    user_sum = {1'b0, enc_mod} + {1'b0, sync};
    if (user_sum >= N_C) begin
      user_sum = user_sum - N_C;
    end
  end

  assign user = user_sum[PW-1:0];

  always_comb begin
    cw_sum = {1'b0, target} - {1'b0, user};
    if (target < user) begin
      cw_sum = cw_sum + N_C;
    end
  end

  assign cw_dist = cw_sum[PW-1:0];

  always_comb begin
    if (cw_dist >= HALF_C) begin
      near_dist = PW'(N_C - {1'b0, cw_dist});
      tick_cw   = 1'b0;
    end else begin
      near_dist = cw_dist;
      tick_cw   = 1'b1;
    end
  end

  always_comb begin
    steps = '0;
    for (int k = 1; k <= STEP_COUNT; k++) begin
      if (32'(near_dist) >= 32'(STEP_SIZE * k)) begin
        steps = STEP_CNT_W'(k);
      end
    end
  end

  always_comb begin
    tick_stop = 1'b0;
    if (32'(near_dist) >= 32'(cfg.full_speed_distance)) begin
      tick_lvl = cfg.full_drive;
    end else if (steps != '0) begin
      tick_lvl = step_drive(steps);
    end else if (near_dist != '0) begin
      tick_lvl = cfg.creep_drive;
    end else begin
      tick_lvl  = '0;
      tick_stop = 1'b1;
    end
  end

  assign man_u   = $unsigned(man);
  assign man_mag = man_u[MAN_W-1] ? (~man_u + MAN_W'(1)) : man_u;

  always_comb begin
    target_nxt = target;
    sync_nxt   = sync;
    res_nxt    = cur;
    unique case (req)
      REQ_SET_TARGET: begin
        if (pos_ok) begin
          target_nxt      = pos_w;
          res_nxt.slewing = 1'b1;
        end
      end
      REQ_SYNC: begin
        if (pos_ok) begin
          sync_nxt = sync_sum[PW-1:0];
        end
      end
      REQ_TICK: begin
        res_nxt.clockwise   = tick_cw;
        res_nxt.drive_level = tick_lvl;
        if (tick_stop) begin
          res_nxt.slewing = 1'b0;
        end
      end
      REQ_ABORT: begin
        res_nxt.slewing     = 1'b0;
        res_nxt.drive_level = '0;
        target_nxt          = user;
      end
      REQ_MANUAL: begin
        res_nxt.clockwise   = !man_u[MAN_W-1] && (man_u != '0);
        res_nxt.drive_level = man_mag[MAN_W-1] ? LVL_MAX : man_mag[LVL_W-1:0];
      end
      REQ_REVERSE: begin
        res_nxt.clockwise = !cur.clockwise;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== bench/axis_slew_drive_controller_top_tb.sv =====
`timescale 1ns / 1ps

module axis_slew_drive_controller_top_tb;
  import asdc_pkg::*;

  localparam int HALF_TURN = 2048;
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  localparam int RANDOM_PER_PHASE = 255;
  localparam int NUM_PHASES = 6;
  localparam int NUM_DIRECTED = 25;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [ENC_W-1:0] enc;
    logic [POS_W-1:0] pos;
    logic [MAN_W-1:0] man;
    bit               typed;
    res_t             want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [39:0]           in_tdata = '0;
  logic [REQ_W-1:0]      in_tuser = REQ_SET_TARGET;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [15:0]           out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FULL_SPEED_DIST;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state and configuration
  logic [POS_W-1:0] aim_count;
  logic [POS_W-1:0] sync_ofs;
  logic [LVL_W-1:0] drive_lvl;
  logic             turn_cw;
  logic             slew_on;
  logic [FSD_W-1:0] fsd_reg;
  logic [LVL_W-1:0] full_reg;
  logic [LVL_W-1:0] creep_reg;

  res_t pending_drive[$];
  int   err_count = 0;
  bit   send_calm = 1'b0;
  bit   take_calm = 1'b0;
  int   take_hold = 0;

  // slewing, clockwise, drive_level
  stim_row_t steer_rows [0:NUM_DIRECTED-1] = '{
    '{REQ_TICK,       12'd0,    12'd0,    9'd0,    1'b1, {1'b0, 1'b1, 8'd0}},
    '{REQ_TICK,       12'd4095, 12'd4095, 9'h1FF,  1'b1, {1'b0, 1'b1, 8'd22}},
    '{REQ_SET_TARGET, 12'd0,    12'd4095, 9'd0,    1'b1, {1'b1, 1'b1, 8'd22}},
    '{REQ_TICK,       12'd0,    12'd0,    9'd0,    1'b1, {1'b1, 1'b0, 8'd22}},
    '{REQ_TICK,       12'd4095, 12'd0,    9'd0,    1'b1, {1'b0, 1'b1, 8'd0}},
    '{REQ_SET_TARGET, 12'd0,    12'd2048, 9'd0,    1'b1, {1'b1, 1'b1, 8'd0}},
    '{REQ_TICK,       12'd0,    12'd0,    9'd0,    1'b1, {1'b1, 1'b0, 8'd255}},
    '{REQ_MANUAL,     12'd0,    12'd0,    9'h100,  1'b1, {1'b1, 1'b0, 8'd255}},
    '{REQ_MANUAL,     12'd0,    12'd0,    9'd255,  1'b1, {1'b1, 1'b1, 8'd255}},
    '{REQ_MANUAL,     12'd0,    12'd0,    9'h101,  1'b1, {1'b1, 1'b0, 8'd255}},
    '{REQ_MANUAL,     12'd0,    12'd0,    9'd0,    1'b1, {1'b1, 1'b0, 8'd0}},
    '{REQ_MANUAL,     12'd0,    12'd0,    9'd1,    1'b1, {1'b1, 1'b1, 8'd1}},
    '{REQ_REVERSE,    12'd0,    12'd0,    9'd0,    1'b1, {1'b1, 1'b0, 8'd1}},
    '{REQ_ABORT,      12'd100,  12'd0,    9'd0,    1'b1, {1'b0, 1'b0, 8'd0}},
    '{REQ_SYNC,       12'd4095, 12'd0,    9'd0,    1'b1, {1'b0, 1'b0, 8'd0}},
    '{REQ_TICK,       12'd99,   12'd0,    9'd0,    1'b1, {1'b0, 1'b1, 8'd0}},
    '{REQ_SET_TARGET, 12'd0,    12'd150,  9'd0,    1'b1, {1'b1, 1'b1, 8'd0}},
    '{REQ_TICK,       12'd99,   12'd0,    9'd0,    1'b1, {1'b1, 1'b1, 8'd50}},
    '{REQ_TICK,       12'd74,   12'd0,    9'd0,    1'b1, {1'b1, 1'b1, 8'd255}},
    '{REQ_TICK,       12'd211,  12'd0,    9'd0,    1'b0, '0},
    '{REQ_TICK,       12'd124,  12'd0,    9'd0,    1'b0, '0},
    '{REQ_TICK,       12'd125,  12'd0,    9'd0,    1'b0, '0},
    '{REQ_SPARE_LO,   12'hFFF,  12'hFFF,  9'h1FF,  1'b0, '0},
    '{REQ_SPARE_HI,   12'd0,    12'd0,    9'd0,    1'b0, '0},
    '{REQ_SYNC,       12'hABC,  12'h543,  9'h0AA,  1'b0, '0}
  };

  axis_slew_drive_controller_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic res_t next_drive(input logic [REQ_W-1:0] req, input logic [ENC_W-1:0] enc,
                                      input logic [POS_W-1:0] pos, input logic [MAN_W-1:0] man);
    logic [POS_W-1:0] user;
    logic [POS_W-1:0] gap;
    logic [MAN_W-1:0] mag;
    int unsigned      stepped;
    res_t             r;
    user = enc + sync_ofs;
    case (req)
      REQ_SET_TARGET: begin
        aim_count = pos;
        slew_on   = 1'b1;
      end
      REQ_SYNC: sync_ofs = pos - enc;
      REQ_TICK: begin
        gap = aim_count - user;
        if (gap >= HALF_TURN) begin
          gap     = 12'd0 - gap;
          turn_cw = 1'b0;
        end else begin
          turn_cw = 1'b1;
        end
        if (gap >= fsd_reg) begin
          drive_lvl = full_reg;
        end else if (gap >= STEP_SIZE) begin
          stepped   = (gap / STEP_SIZE) * STEP_SIZE;
          drive_lvl = (stepped > 250) ? 8'd250 : stepped[LVL_W-1:0];
        end else if (gap != 0) begin
          drive_lvl = creep_reg;
        end else begin
          slew_on   = 1'b0;
          drive_lvl = '0;
        end
      end
      REQ_ABORT: begin
        slew_on   = 1'b0;
        drive_lvl = '0;
        aim_count = user;
      end
      REQ_MANUAL: begin
        mag       = man[MAN_W-1] ? (9'd0 - man) : man;
        turn_cw   = !man[MAN_W-1] && (man != 0);
        drive_lvl = (mag > 255) ? LVL_MAX : mag[LVL_W-1:0];
      end
      REQ_REVERSE: turn_cw = !turn_cw;
      default: ;
    endcase
    r.slewing     = slew_on;
    r.clockwise   = turn_cw;
    r.drive_level = drive_lvl;
    return r;
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[9:0]);
      if (pending_drive.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: drive %0d cw %0b slew %0b",
                   got.drive_level, got.clockwise, got.slewing);
      end else begin
        want = pending_drive.pop_front();
        if (got.drive_level !== want.drive_level || got.clockwise !== want.clockwise ||
            got.slewing !== want.slewing) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: drive %0d/%0d cw %0b/%0b slew %0b/%0b (expected/actual)",
                     want.drive_level, got.drive_level, want.clockwise, got.clockwise,
                     want.slewing, got.slewing);
        end
      end
      if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
    end
    if (take_hold != 0) begin
      out_tready <= (take_hold == 1);
      take_hold  = take_hold - 1;
    end else if (rst_n && out_tvalid && out_tready) begin
      take_hold = draw_wait(take_calm);
      if (take_hold != 0) out_tready <= 1'b0;
    end
  end

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [ENC_W-1:0] enc,
                          input logic [POS_W-1:0] pos, input logic [MAN_W-1:0] man,
                          input bit typed, input res_t want);
    res_t        p;
    int unsigned g;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'd0, man, pos, enc};
    do @(posedge clk); while (!in_tready);
    p = next_drive(req, enc, pos, man);
    pending_drive.push_back(typed ? want : p);
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    g = draw_wait(send_calm);
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_FULL_SPEED_DIST: fsd_reg   = val[FSD_W-1:0];
      CFG_FULL_DRIVE:      full_reg  = val[LVL_W-1:0];
      CFG_CREEP_DRIVE:     creep_reg = val[LVL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic random_tick();
    logic [POS_W-1:0] d;
    logic [POS_W-1:0] delta;
    case ($urandom_range(0, 5))
      0:       d = 12'd0;
      1:       d = POS_W'($urandom_range(1, 24));
      2:       d = POS_W'($urandom_range(25, 300));
      3:       d = POS_W'($urandom_range(250, HALF_TURN - 1));
      4:       d = POS_W'($urandom_range(HALF_TURN - 8, HALF_TURN));
      default: d = POS_W'($urandom_range(0, ENC_MAX));
    endcase
    delta = $urandom_range(0, 1) ? (12'd0 - d) : d;
    send_req(REQ_TICK, aim_count - sync_ofs - delta, POS_W'($urandom_range(0, ENC_MAX)),
             MAN_W'($urandom_range(0, 511)), 1'b0, '0);
  endtask

  task automatic random_phase();
    int          counted;
    int unsigned pick;
    logic [REQ_W-1:0] req;
    counted = 0;
    while (counted < RANDOM_PER_PHASE) begin
      pick = $urandom_range(0, 99);
      if (pick >= 60 && pick < 64) begin
        req = $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
      end else if (pick >= 92) begin
        req = REQ_W'($urandom_range(0, 7));
      end else begin
        req = REQ_TICK;
        if (pick < 8) req = REQ_SET_TARGET;
        else if (pick < 14) req = REQ_SYNC;
        else if (pick < 60) req = REQ_TICK;
        else if (pick < 72) req = REQ_ABORT;
        else if (pick < 82) req = REQ_MANUAL;
        else req = REQ_REVERSE;
      end
      if (req == REQ_TICK && pick < 60)
        random_tick();
      else
        send_req(req, ENC_W'($urandom_range(0, ENC_MAX)), POS_W'($urandom_range(0, ENC_MAX)),
                 MAN_W'($urandom_range(0, 511)), 1'b0, '0);
      counted++;
    end
  endtask

  initial begin : stimulus
    logic [FSD_W-1:0] fsd_set [0:NUM_PHASES-1];
    logic [LVL_W-1:0] full_set [0:NUM_PHASES-1];
    logic [LVL_W-1:0] creep_set [0:NUM_PHASES-1];
    fsd_set   = '{FSD_RST, 12'd4095, 12'd1, 12'd0, 12'd276, 12'd64};
    full_set  = '{FULL_RST, 8'd0, 8'd255, 8'd128, 8'd200, 8'd255};
    creep_set = '{CREEP_RST, 8'd255, 8'd0, 8'd7, 8'd22, 8'd22};
    fsd_set[NUM_PHASES-1]   = FSD_W'($urandom_range(0, ENC_MAX));
    full_set[NUM_PHASES-1]  = LVL_W'($urandom_range(0, 255));
    creep_set[NUM_PHASES-1] = LVL_W'($urandom_range(0, 255));

    aim_count = '0;
    sync_ofs  = '0;
    drive_lvl = '0;
    turn_cw   = 1'b1;
    slew_on   = 1'b0;
    fsd_reg   = FSD_RST;
    full_reg  = FULL_RST;
    creep_reg = CREEP_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_req(steer_rows[i].req, steer_rows[i].enc, steer_rows[i].pos, steer_rows[i].man,
               steer_rows[i].typed, steer_rows[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        drain_results();
        write_reg(CFG_FULL_SPEED_DIST, CFG_DATA_W'(fsd_set[ph]));
        write_reg(CFG_FULL_DRIVE, CFG_DATA_W'(full_set[ph]));
        write_reg(CFG_CREEP_DRIVE, CFG_DATA_W'(creep_set[ph]));
        cfg_we <= 1'b0;
        @(posedge clk);
      end
      random_phase();
    end

    drain_results();
    if (pending_drive.size() != 0) err_count++;
    if (err_count == 0)
      $display("axis_slew_drive_controller_top_tb: clean");
    else
      $display("axis_slew_drive_controller_top_tb: errors");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("axis_slew_drive_controller_top_tb: errors");
    $finish;
  end

endmodule
